[src/skf3_pkg.sv]
// Shared types, constants and sequencer states of the three-axis scalar Kalman filter.
package skf3_pkg;

    localparam int NUM_AXES_DEF = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int DIV_STEPS    = 24;

    localparam logic [24:0] GAIN_ONE  = 25'd16777216;
    localparam logic [31:0] COV_RESET = 32'd335544;
    localparam logic [31:0] Q_RESET   = 32'd16777;
    localparam logic [31:0] R_RESET   = 32'd9110028;

    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_MEASURE_NOISE = 1'b1;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [15:0] measurement;
    } in_t;

    typedef struct packed {
        logic [1:0]         axis_out;
        logic signed [31:0] estimate;
        logic [24:0]        gain;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_DENOM,
        S_DIV_INIT,
        S_DIV,
        S_MX_LO,
        S_MX_HI,
        S_MX_SUM,
        S_EST,
        S_PSUM,
        S_PUT
    } state_t;

endpackage

[src/scalar_kalman_filter_3axis.sv]
// Top level of the three-axis scalar Kalman filter with a shared divider and multiplier.
//
// A request on the s_ channel carries an axis number and a signed 16-bit sample.
// The block predicts that axis's covariance, divides for the gain with a radix-2
// restoring divider, and then runs four passes of one shared
// 18 x 26 multiplier to update the estimate and the covariance.
// Each request yields exactly one result on the m_ channel: the axis, the new
// Q15.16 estimate and the Q1.24 gain. A request for an axis at or above NUM_AXES
// leaves all state alone and returns an estimate and a gain of zero.
// The divider is skipped and the gain is one when R is zero or the predicted covariance
// is at its maximum; a request for an absent axis goes straight to the result. s_ready
// is high only while the sequencer is idle, so a new request is not taken before the
// last one has reached the output register.
// The result sits in an output register, so the next
// request is accepted while an earlier result still waits for m_ready; if the
// receiver stalls longer, the following result is held until the register frees.
// The APB port sets process noise Q at address 0 and measurement noise R at
// address 4, both unsigned Q8.24; write them only while the block is idle.
// Synchronous reset restores Q and R to their defaults, all estimates to zero
// and all covariances to 0.02, and drops m_valid.
module scalar_kalman_filter_3axis #(
    parameter int NUM_AXES = skf3_pkg::NUM_AXES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  skf3_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output skf3_pkg::out_t                    m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [skf3_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import skf3_pkg::*;

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    state_t state_reg, state_next;

    logic [31:0]        q_reg, r_reg;
    logic signed [31:0] est_mem_reg [NUM_AXES];
    logic [31:0]        cov_mem_reg [NUM_AXES];

    logic [1:0]         axis_reg, axis_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [15:0] meas_reg, meas_next;
    logic signed [31:0] x_reg, x_next;
    logic [31:0]        p_pred_reg, p_pred_next;
    logic [31:0]        den_reg, den_next;
    logic signed [32:0] innov_reg, innov_next;
    logic [31:0]        rem_reg, rem_next;
    logic [23:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [24:0]        gain_reg, gain_next;
    logic signed [43:0] prod_reg, prod_next;
    logic signed [57:0] acc_reg, acc_next;
    logic signed [31:0] est_reg, est_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic               s_fire, axis_ok, out_free, cfg_wr;
    logic [31:0]        axis_ext;
    logic [32:0]        sum_pq, sum_pr, rem_dbl;
    logic               div_ge;
    logic signed [17:0] mul_a;
    logic signed [25:0] mul_b;
    logic [24:0]        one_minus_gain;
    logic signed [57:0] prod_ext, acc_plus_hi;
    logic signed [34:0] est_sum;
    logic [31:0]        cov_new;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign axis_ext = 32'(s_data.axis);
    assign axis_ok  = (axis_ext < 32'(NUM_AXES));
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MEASURE_NOISE) ? r_reg : q_reg;

    assign sum_pq  = {1'b0, cov_mem_reg[idx_reg]} + {1'b0, q_reg};
    assign sum_pr  = {1'b0, p_pred_reg} + {1'b0, r_reg};
    assign rem_dbl = {rem_reg, 1'b0};
    assign div_ge  = (rem_dbl >= {1'b0, den_reg});

    assign one_minus_gain = GAIN_ONE - gain_reg;

    always_comb begin
        unique case (state_reg)
            S_MX_LO: begin
                mul_a = {1'b0, innov_reg[16:0]};
                mul_b = {1'b0, gain_reg};
            end
            S_MX_HI: begin
                mul_a = 18'($signed(innov_reg[32:17]));
                mul_b = {1'b0, gain_reg};
            end
            S_MX_SUM: begin
                mul_a = {1'b0, p_pred_reg[16:0]};
                mul_b = {1'b0, one_minus_gain};
            end
            default: begin
                mul_a = {3'b000, p_pred_reg[31:17]};
                mul_b = {1'b0, one_minus_gain};
            end
        endcase
    end

    assign prod_ext    = 58'(prod_reg);
    assign acc_plus_hi = acc_reg + (prod_ext <<< 17);
    assign est_sum     = 35'(x_reg) + 35'($signed(acc_reg[57:24]));
    assign cov_new     = acc_plus_hi[55:24];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = axis_ok ? S_PRED : S_PUT;
                end
            end
            S_PRED:     state_next = S_DENOM;
            S_DENOM:    state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = (p_pred_reg >= den_reg) ? S_MX_LO : S_DIV;
            S_DIV: begin
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = S_MX_LO;
                end
            end
            S_MX_LO:  state_next = S_MX_HI;
            S_MX_HI:  state_next = S_MX_SUM;
            S_MX_SUM: state_next = S_EST;
            S_EST:    state_next = S_PSUM;
            S_PSUM:   state_next = S_PUT;
            S_PUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        axis_next    = axis_reg;
        idx_next     = idx_reg;
        meas_next    = meas_reg;
        x_next       = x_reg;
        p_pred_next  = p_pred_reg;
        den_next     = den_reg;
        innov_next   = innov_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        gain_next    = gain_reg;
        prod_next    = mul_a * mul_b;
        acc_next     = acc_reg;
        est_next     = est_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    axis_next = s_data.axis;
                    idx_next  = axis_ext[IDX_W-1:0];
                    meas_next = s_data.measurement;
                    gain_next = '0;
                    est_next  = '0;
                end
            end
            S_PRED: begin
                p_pred_next = sum_pq[32] ? 32'hFFFF_FFFF : sum_pq[31:0];
                x_next      = est_mem_reg[idx_reg];
            end
            S_DENOM: begin
                den_next   = sum_pr[32] ? 32'hFFFF_FFFF : sum_pr[31:0];
                innov_next = {meas_reg[15], meas_reg, 16'h0000} - 33'(x_reg);
            end
            S_DIV_INIT: begin
                gain_next = GAIN_ONE;
                rem_next  = p_pred_reg;
                quo_next  = '0;
                cnt_next  = '0;
            end
            S_DIV: begin
                rem_next  = div_ge ? 32'(rem_dbl - {1'b0, den_reg}) : rem_dbl[31:0];
                quo_next  = {quo_reg[22:0], div_ge};
                cnt_next  = cnt_reg + 5'd1;
                gain_next = {1'b0, quo_reg[22:0], div_ge};
            end
            S_MX_HI:  acc_next = prod_ext;
            S_MX_SUM: acc_next = acc_plus_hi;
            S_EST: begin
                acc_next = prod_ext;
                if (est_sum > 35'sh0_7FFF_FFFF) begin
                    est_next = 32'sh7FFF_FFFF;
                end else if (est_sum < -35'sh0_8000_0000) begin
                    est_next = 32'sh8000_0000;
                end else begin
                    est_next = est_sum[31:0];
                end
            end
            S_PUT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.axis_out = axis_reg;
                    m_data_next.estimate = est_reg;
                    m_data_next.gain     = gain_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            q_reg       <= Q_RESET;
            r_reg       <= R_RESET;
            for (int i = 0; i < NUM_AXES; i++) begin
                est_mem_reg[i] <= '0;
                cov_mem_reg[i] <= COV_RESET;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                if (paddr[2] == REG_MEASURE_NOISE) begin
                    r_reg <= pwdata;
                end else begin
                    q_reg <= pwdata;
                end
            end
            if (state_reg == S_PSUM) begin
                est_mem_reg[idx_reg] <= est_reg;
                cov_mem_reg[idx_reg] <= cov_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        axis_reg   <= axis_next;
        idx_reg    <= idx_next;
        meas_reg   <= meas_next;
        x_reg      <= x_next;
        p_pred_reg <= p_pred_next;
        den_reg    <= den_next;
        innov_reg  <= innov_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        gain_reg   <= gain_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        est_reg    <= est_next;
        m_data_reg <= m_data_next;
    end

    a_div_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("Divider remainder is not below the denominator.");

    a_gain_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MX_LO) |-> (gain_reg <= GAIN_ONE))
        else $error("Gain exceeds one.");

    a_bad_axis_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !axis_ok) |=> (state_reg == S_PUT && gain_reg == '0 && est_reg == '0))
        else $error("Request for an absent axis did not go straight to the result.");

    a_cov_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PSUM) |-> (cov_new <= p_pred_reg))
        else $error("Updated covariance exceeds the predicted covariance.");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("Result valid survived reset.");

endmodule
